FILE: sv/tkfat_pkg.sv
// Shared types and constants for the top-k frequent address tracker.
package tkfat_pkg;
    localparam int unsigned ADDR_W = 64;
    localparam int unsigned KIND_W = 8;
    localparam int unsigned CNT_W = 32;
    localparam int unsigned SLOT_W = 6;
    localparam logic [KIND_W-1:0] COUNTED_KIND = 8'd3;
    localparam logic [CNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [0:0] {
        OP_RECORD = 1'b0,
        OP_SCAN   = 1'b1
    } opcode_t;

    typedef struct packed {
        logic              is_scan;
        logic [ADDR_W-1:0] addr;
    } cmd_t;
endpackage

FILE: sv/tkfat_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module tkfat_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: sv/tkfat_front.sv
// Front end: accepts requests, drops uncounted records, pushes commands into a short queue.
module tkfat_front
    import tkfat_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_opcode,
    input  logic [ADDR_W-1:0] s_page_address,
    input  logic [KIND_W-1:0] s_access_kind,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cmd_t              cmd
);
    localparam int unsigned QD = 2;

    cmd_t q_reg [QD];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    logic       push;
    logic       pop;
    logic       keep;

    assign s_ready   = (cnt_reg != 2'(QD));
    assign keep      = (opcode_t'(s_opcode) == OP_SCAN) || (s_access_kind == COUNTED_KIND);
    assign push      = s_valid && s_ready && keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_reg] <= '{is_scan: s_opcode, addr: s_page_address};
        end
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

FILE: sv/tkfat_back.sv
// Back end: table search and update, heap build over a scan, and result emission.
module tkfat_back
    import tkfat_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 256,
    parameter int unsigned TOP_K = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ADDR_W-1:0] m_pinned_address,
    output logic [SLOT_W-1:0] m_slot,
    output logic              m_last
);
    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned HW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam int unsigned FW = $clog2(TOP_K + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RRD   = 10'b0000000010,
        S_RCMP  = 10'b0000000100,
        S_RINC  = 10'b0000001000,
        S_SRD   = 10'b0000010000,
        S_SUSE  = 10'b0000100000,
        S_UP    = 10'b0001000000,
        S_DOWN  = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_ERD   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [IW-1:0] idx_reg;
    logic [IW:0]   free_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] hadr_reg [TOP_K];
    logic [CNT_W-1:0]  hcnt_reg [TOP_K];
    logic [FW-1:0] fill_reg;
    logic [HW-1:0] pos_reg;
    logic [HW-1:0] eslot_reg;

    logic              t_we;
    logic [IW-1:0]     t_waddr;
    logic [ADDR_W-1:0] t_wadr;
    logic [CNT_W-1:0]  t_wcnt;
    logic [ADDR_W-1:0] t_radr;
    logic [CNT_W-1:0]  t_rcnt;

    tkfat_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH)) u_adr (
        .aclk(aclk), .we(t_we), .waddr(t_waddr), .wdata(t_wadr),
        .raddr(idx_reg), .rdata(t_radr)
    );
    tkfat_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_DEPTH)) u_cnt (
        .aclk(aclk), .we(t_we), .waddr(t_waddr), .wdata(t_wcnt),
        .raddr(idx_reg), .rdata(t_rcnt)
    );

    logic idx_end;
    logic hit;
    logic [IW:0]   free_now;
    logic [HW-1:0] par;
    logic [HW+1:0] lc, rc;
    logic [HW-1:0] best;
    logic [CNT_W-1:0] bcnt;

    assign idx_end  = (idx_reg == IW'(TABLE_DEPTH - 1));
    assign hit      = valid_reg[idx_reg] && (t_radr == addr_reg);
    assign free_now = (free_reg == (IW+1)'(TABLE_DEPTH) && !valid_reg[idx_reg])
                    ? {1'b0, idx_reg} : free_reg;
    assign par      = HW'((pos_reg - HW'(1)) >> 1);
    assign lc       = {1'b0, pos_reg, 1'b1};
    assign rc       = {1'b0, pos_reg, 1'b0} + (HW+2)'(2);

    always_comb begin
        best = pos_reg;
        bcnt = hcnt_reg[pos_reg];
        if (lc < (HW+2)'(fill_reg) && hcnt_reg[lc[HW-1:0]] < bcnt) begin
            best = lc[HW-1:0];
            bcnt = hcnt_reg[lc[HW-1:0]];
        end
        if (rc < (HW+2)'(fill_reg) && hcnt_reg[rc[HW-1:0]] < bcnt) begin
            best = rc[HW-1:0];
        end
    end

    assign cmd_ready        = (state_reg == S_IDLE);
    assign m_valid          = (state_reg == S_EMIT);
    assign m_pinned_address = hadr_reg[eslot_reg];
    assign m_slot           = SLOT_W'(eslot_reg);
    assign m_last           = (FW'(eslot_reg) + FW'(1) == fill_reg);

    always_comb begin
        t_we    = 1'b0;
        t_waddr = idx_reg;
        t_wadr  = addr_reg;
        t_wcnt  = (t_rcnt == COUNT_MAX) ? t_rcnt : t_rcnt + CNT_W'(1);
        if (state_reg == S_RINC) begin
            t_we = 1'b1;
        end else if (state_reg == S_RCMP && idx_end && !hit
                     && free_now != (IW+1)'(TABLE_DEPTH)) begin
            t_we    = 1'b1;
            t_waddr = free_now[IW-1:0];
            t_wcnt  = CNT_W'(1);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (cmd_valid) state_next = cmd.is_scan ? S_SRD : S_RRD;
            S_RRD:  state_next = S_RCMP;
            S_RCMP: begin
                if (hit) state_next = S_RINC;
                else if (idx_end) state_next = S_IDLE;
                else state_next = S_RRD;
            end
            S_RINC: state_next = S_IDLE;
            S_SRD:  state_next = S_SUSE;
            S_SUSE: begin
                if (valid_reg[idx_reg]) begin
                    if (fill_reg != FW'(TOP_K)) state_next = S_UP;
                    else if (hcnt_reg[0] < t_rcnt) state_next = S_DOWN;
                    else state_next = idx_end ? S_ERD : S_SRD;
                end else begin
                    state_next = idx_end ? S_ERD : S_SRD;
                end
            end
            S_UP: begin
                if (pos_reg == '0 || !(hcnt_reg[pos_reg] < hcnt_reg[par]))
                    state_next = idx_end ? S_ERD : S_SRD;
            end
            S_DOWN: begin
                if (best == pos_reg) state_next = idx_end ? S_ERD : S_SRD;
            end
            S_ERD:  state_next = (fill_reg == '0) ? S_IDLE : S_EMIT;
            S_EMIT: if (m_ready && m_last) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            fill_reg  <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE: begin
                    idx_reg   <= '0;
                    free_reg  <= (IW+1)'(TABLE_DEPTH);
                    addr_reg  <= cmd.addr;
                    eslot_reg <= '0;
                    if (cmd_valid && cmd.is_scan) fill_reg <= '0;
                end
                S_RCMP: begin
                    free_reg <= free_now;
                    if (t_we) valid_reg[t_waddr] <= 1'b1;
                    if (!hit && !idx_end) idx_reg <= idx_reg + IW'(1);
                end
                S_SUSE: begin
                    if (valid_reg[idx_reg]) begin
                        if (fill_reg != FW'(TOP_K)) begin
                            hadr_reg[fill_reg[HW-1:0]] <= t_radr;
                            hcnt_reg[fill_reg[HW-1:0]] <= t_rcnt;
                            pos_reg  <= fill_reg[HW-1:0];
                            fill_reg <= fill_reg + FW'(1);
                        end else if (hcnt_reg[0] < t_rcnt) begin
                            hadr_reg[0] <= t_radr;
                            hcnt_reg[0] <= t_rcnt;
                            pos_reg     <= '0;
                        end else if (!idx_end) begin
                            idx_reg <= idx_reg + IW'(1);
                        end
                    end else if (!idx_end) begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                S_UP: begin
                    if (pos_reg != '0 && hcnt_reg[pos_reg] < hcnt_reg[par]) begin
                        hadr_reg[pos_reg] <= hadr_reg[par];
                        hcnt_reg[pos_reg] <= hcnt_reg[par];
                        hadr_reg[par]     <= hadr_reg[pos_reg];
                        hcnt_reg[par]     <= hcnt_reg[pos_reg];
                        pos_reg           <= par;
                    end else if (!idx_end) begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                S_DOWN: begin
                    if (best != pos_reg) begin
                        hadr_reg[pos_reg] <= hadr_reg[best];
                        hcnt_reg[pos_reg] <= hcnt_reg[best];
                        hadr_reg[best]    <= hadr_reg[pos_reg];
                        hcnt_reg[best]    <= hcnt_reg[pos_reg];
                        pos_reg           <= best;
                    end else if (!idx_end) begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                S_EMIT: if (m_ready) eslot_reg <= eslot_reg + HW'(1);
                default: ;
            endcase
        end
    end
endmodule

FILE: sv/top_k_frequent_address_tracker_core.sv
// Top level: request front end, command queue and table/heap back end.
// Record: compares table entries in turn; a hit writes back the incremented count,
// a miss writes the address with count 1 into the first free entry, if there is one.
// Scan: walks the table, adding entries to the min-heap or replacing a smaller root,
// sifting after each, then emits one result per cycle while m_ready is high.
// Front queue holds two requests; uncounted records are dropped there.
// Reset (aresetn low, synchronous) empties the queue, the table valid bits and the heap.
module top_k_frequent_address_tracker_core
    import tkfat_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 256,
    parameter int unsigned TOP_K = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_opcode,
    input  logic [ADDR_W-1:0] s_page_address,
    input  logic [KIND_W-1:0] s_access_kind,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ADDR_W-1:0] m_pinned_address,
    output logic [SLOT_W-1:0] m_slot,
    output logic              m_last
);
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    tkfat_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_page_address(s_page_address), .s_access_kind(s_access_kind),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    tkfat_back #(.TABLE_DEPTH(TABLE_DEPTH), .TOP_K(TOP_K)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pinned_address(m_pinned_address), .m_slot(m_slot), .m_last(m_last)
    );
endmodule

FILE: tb/top_k_frequent_address_tracker_core_tb.sv
// Self-checking testbench for the top-k frequent address tracker core.
module top_k_frequent_address_tracker_core_tb;
    import tkfat_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH = 256;
    localparam int unsigned K = 16;
    localparam longint unsigned CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } pin_t;

    typedef struct {
        opcode_t           op;
        logic [ADDR_W-1:0] addr;
        logic [KIND_W-1:0] kind;
        int                n_exp;
        logic [ADDR_W-1:0] exp_addr;
    } row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_opcode;
    logic [ADDR_W-1:0] s_page_address;
    logic [KIND_W-1:0] s_access_kind;
    logic              m_valid;
    logic              m_ready;
    logic [ADDR_W-1:0] m_pinned_address;
    logic [SLOT_W-1:0] m_slot;
    logic              m_last;

    logic [ADDR_W-1:0] tbl_addr [DEPTH];
    logic [CNT_W-1:0]  tbl_cnt [DEPTH];
    logic              tbl_used [DEPTH];
    logic [ADDR_W-1:0] hp_addr [K];
    logic [CNT_W-1:0]  hp_cnt [K];
    int                hp_fill;

    pin_t              pending_pins[$];
    logic [ADDR_W-1:0] pool[$];
    int                errors;
    int                src_idle;
    int                snk_idle;
    bit                hold_off;
    longint unsigned   cycles = 0;

    top_k_frequent_address_tracker_core #(.TABLE_DEPTH(DEPTH), .TOP_K(K)) i_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic report(input string what, input logic [ADDR_W-1:0] got,
                          input logic [ADDR_W-1:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic void count_access(input logic [ADDR_W-1:0] a);
        int free_i;
        free_i = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (tbl_used[i]) begin
                if (tbl_addr[i] == a) begin
                    if (tbl_cnt[i] != COUNT_MAX) tbl_cnt[i]++;
                    return;
                end
            end else if (free_i < 0) begin
                free_i = i;
            end
        end
        if (free_i >= 0) begin
            tbl_used[free_i] = 1'b1;
            tbl_addr[free_i] = a;
            tbl_cnt[free_i] = CNT_W'(1);
        end
    endfunction

    function automatic void hp_swap(input int a, input int b);
        logic [ADDR_W-1:0] ta;
        logic [CNT_W-1:0]  tc;
        ta = hp_addr[a]; tc = hp_cnt[a];
        hp_addr[a] = hp_addr[b]; hp_cnt[a] = hp_cnt[b];
        hp_addr[b] = ta; hp_cnt[b] = tc;
    endfunction

    function automatic int predict_top_set();
        int pos;
        int par;
        int l;
        int r;
        int best;
        hp_fill = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (!tbl_used[i]) continue;
            if (hp_fill < K) begin
                hp_addr[hp_fill] = tbl_addr[i];
                hp_cnt[hp_fill] = tbl_cnt[i];
                pos = hp_fill;
                while (pos > 0) begin
                    par = (pos - 1) / 2;
                    if (hp_cnt[pos] < hp_cnt[par]) begin
                        hp_swap(pos, par);
                        pos = par;
                    end else break;
                end
                hp_fill++;
            end else if (hp_cnt[0] < tbl_cnt[i]) begin
                hp_addr[0] = tbl_addr[i];
                hp_cnt[0] = tbl_cnt[i];
                pos = 0;
                forever begin
                    l = 2 * pos + 1;
                    r = 2 * pos + 2;
                    best = pos;
                    if (l < hp_fill && hp_cnt[l] < hp_cnt[best]) best = l;
                    if (r < hp_fill && hp_cnt[r] < hp_cnt[best]) best = r;
                    if (best == pos) break;
                    hp_swap(pos, best);
                    pos = best;
                end
            end
        end
        for (int k = 0; k < hp_fill; k++)
            pending_pins.push_back('{hp_addr[k], SLOT_W'(k), k + 1 == hp_fill});
        return hp_fill;
    endfunction

    task automatic send(input opcode_t op, input logic [ADDR_W-1:0] a,
                        input logic [KIND_W-1:0] kind);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_page_address <= a;
        s_access_kind <= kind;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == OP_SCAN) void'(predict_top_set());
        else if (kind == COUNTED_KIND) count_access(a);
    endtask

    task automatic drain();
        do @(posedge aclk); while (pending_pins.size() != 0);
    endtask

    function automatic logic [ADDR_W-1:0] pick_addr();
        int r;
        r = $urandom_range(99);
        if (pool.size() == 0 || r < 15) begin
            pool.push_back({$urandom, $urandom});
            return pool[$];
        end
        if (r < 60) return pool[$urandom_range(pool.size() < 8 ? pool.size() - 1 : 7)];
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    task automatic random_run(input int n);
        int r;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(99);
            if (r < 8) send(OP_SCAN, {$urandom, $urandom}, KIND_W'($urandom));
            else if (r < 88) send(OP_RECORD, pick_addr(), COUNTED_KIND);
            else send(OP_RECORD, pick_addr(), KIND_W'($urandom));
        end
        send(OP_SCAN, '0, '0);
        s_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        pin_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !hold_off && ($urandom_range(99) >= snk_idle);
            if (m_valid && m_ready) begin
                if (pending_pins.size() == 0) begin
                    report("unexpected result", m_pinned_address, '0);
                end else begin
                    want = pending_pins.pop_front();
                    if (m_pinned_address !== want.addr)
                        report("pinned_address", m_pinned_address, want.addr);
                    if (m_slot !== want.slot)
                        report("slot", ADDR_W'(m_slot), ADDR_W'(want.slot));
                    if (m_last !== want.last)
                        report("last", ADDR_W'(m_last), ADDR_W'(want.last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("top_k_frequent_address_tracker_core regression: fail");
            $finish;
        end
    end

    initial begin
        row_t rows[$];
        errors = 0;
        src_idle = 0;
        snk_idle = 0;
        hold_off = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_opcode = OP_RECORD;
        s_page_address = '0;
        s_access_kind = '0;
        for (int i = 0; i < DEPTH; i++) tbl_used[i] = 1'b0;
        hp_fill = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows.push_back('{OP_SCAN, '1, '1, 0, '0});
        rows.push_back('{OP_RECORD, '0, COUNTED_KIND, -1, '0});
        rows.push_back('{OP_SCAN, '0, '0, 1, '0});
        rows.push_back('{OP_RECORD, '1, 8'd0, -1, '0});
        rows.push_back('{OP_RECORD, '1, 8'hFF, -1, '0});
        rows.push_back('{OP_RECORD, '1, 8'd2, -1, '0});
        rows.push_back('{OP_SCAN, '1, '1, 1, '0});
        rows.push_back('{OP_RECORD, '1, COUNTED_KIND, -1, '0});
        rows.push_back('{OP_RECORD, 64'h5555_5555_5555_5555, COUNTED_KIND, -1, '0});
        rows.push_back('{OP_RECORD, 64'hAAAA_AAAA_AAAA_AAAA, COUNTED_KIND, -1, '0});
        rows.push_back('{OP_RECORD, '1, COUNTED_KIND, -1, '0});
        rows.push_back('{OP_RECORD, '0, COUNTED_KIND, -1, '0});
        rows.push_back('{OP_SCAN, '0, '0, -1, '0});
        foreach (rows[i]) begin
            send(rows[i].op, rows[i].addr, rows[i].kind);
            if (rows[i].n_exp >= 0 && rows[i].op == OP_SCAN) begin
                if (hp_fill != rows[i].n_exp)
                    report("scan size", ADDR_W'(hp_fill), ADDR_W'(rows[i].n_exp));
                if (hp_fill == 1 && hp_addr[0] !== rows[i].exp_addr)
                    report("lone entry", hp_addr[0], rows[i].exp_addr);
            end
        end
        s_valid <= 1'b0;
        drain();

        random_run(40);
        drain();
        src_idle = 53;
        random_run(30);
        drain();
        src_idle = 0;
        snk_idle = 53;
        random_run(30);
        drain();
        src_idle = 17;
        snk_idle = 17;
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            random_run(20);
        join
        drain();
        src_idle = 0;
        snk_idle = 0;
        for (int j = 0; j < 250; j++) send(OP_RECORD, {$urandom, $urandom}, COUNTED_KIND);
        for (int j = 0; j < 20; j++) send(OP_RECORD, pool[$urandom_range(pool.size() - 1)],
                                           COUNTED_KIND);
        send(OP_SCAN, '0, '0);
        send(OP_RECORD, {$urandom, $urandom}, COUNTED_KIND);
        send(OP_SCAN, '0, '0);
        s_valid <= 1'b0;
        drain();

        repeat (1200) @(posedge aclk);
        if (errors == 0 && pending_pins.size() == 0) begin
            $display("top_k_frequent_address_tracker_core regression: pass");
        end else begin
            $display("top_k_frequent_address_tracker_core regression: fail");
        end
        $finish;
    end
endmodule

FILE: sim.f
sv/tkfat_pkg.sv
sv/tkfat_ram.sv
sv/tkfat_front.sv
sv/tkfat_back.sv
sv/top_k_frequent_address_tracker_core.sv
tb/top_k_frequent_address_tracker_core_tb.sv
